// ===== rtl/lpht_pkg.sv =====
// Shared types and constants for the linear probe hash table.
// No dependencies.
`timescale 1ns / 1ps
package lpht_pkg;
	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] HASH_MULT = 64'h00000100000001B3;
	localparam int          HASH_MULT_SHIFT = 40;
	localparam logic [8:0]  HASH_MULT_LOW = 9'h1B3;

	typedef enum logic [1:0] {
		CMD_GET    = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_HASH,
		S_HOME,
		S_READ,
		S_CHECK,
		S_WRITE,
		S_CLEAR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic hash_step;
		logic set_home;
		logic probe_step;
		logic clr_start;
		logic clr_step;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic hash_last;
		logic clr_last;
		logic slot_live;
		logic slot_used;
		logic key_match;
		logic scan_last;
	} sts_t;
endpackage

// ===== rtl/lpht_ctrl.sv =====
// Controller state machine for the linear probe hash table.
// Uses lpht_pkg; drives lpht_dp.
`timescale 1ns / 1ps
module lpht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  lpht_pkg::cmd_t  cmd,
	input  logic            out_busy,
	input  lpht_pkg::sts_t  sts,
	output lpht_pkg::ctl_t  ctl,
	output logic            idle
);
	lpht_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		idle = 1'b0;
		unique case (state_q)
			lpht_pkg::S_INIT: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) state_d = lpht_pkg::S_IDLE;
			end
			lpht_pkg::S_IDLE: begin
				idle = !out_busy;
				if (in_fire) begin
					ctl.load = 1'b1;
					state_d = (cmd == lpht_pkg::CMD_CLEAR) ? lpht_pkg::S_CLEAR
						: lpht_pkg::S_HASH;
					if (cmd == lpht_pkg::CMD_CLEAR) ctl.clr_start = 1'b1;
				end
			end
			lpht_pkg::S_HASH: begin
				ctl.hash_step = 1'b1;
				if (sts.hash_last) state_d = lpht_pkg::S_HOME;
			end
			lpht_pkg::S_HOME: begin
				ctl.set_home = 1'b1;
				state_d = lpht_pkg::S_READ;
			end
			lpht_pkg::S_READ: state_d = lpht_pkg::S_CHECK;
			lpht_pkg::S_CHECK: begin
				if ((sts.slot_live && sts.key_match) || !sts.slot_used || sts.scan_last)
					state_d = lpht_pkg::S_WRITE;
				else begin
					ctl.probe_step = 1'b1;
					state_d = lpht_pkg::S_READ;
				end
			end
			lpht_pkg::S_WRITE: begin
				ctl.finish = 1'b1;
				state_d = lpht_pkg::S_OUT;
			end
			lpht_pkg::S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					ctl.finish = 1'b1;
					state_d = lpht_pkg::S_OUT;
				end
			end
			lpht_pkg::S_OUT: state_d = lpht_pkg::S_IDLE;
			default: state_d = lpht_pkg::S_IDLE;
		endcase
	end
endmodule

// ===== rtl/lpht_dp.sv =====
// Datapath: FNV-1a hash unit, slot memories, probe and result registers.
// Uses lpht_pkg; commanded by lpht_ctrl.
`timescale 1ns / 1ps
module lpht_dp #(
	parameter int SLOTS = 1024,
	parameter int KEY_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpht_pkg::ctl_t    ctl,
	input  lpht_pkg::cmd_t    cmd,
	input  logic [63:0]       key,
	input  logic [63:0]       value,
	output lpht_pkg::sts_t    sts,
	output logic              res_found,
	output lpht_pkg::status_t res_status,
	output logic [63:0]       res_value,
	output logic [10:0]       res_count
);
	localparam int IW = $clog2(SLOTS);
	localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam logic [63:0] KMASK = (KEY_BYTES >= 8) ? {64{1'b1}}
		: ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	logic [63:0] slot_key [SLOTS];
	logic [63:0] slot_value [SLOTS];
	logic [1:0]  slot_flags [SLOTS];

	lpht_pkg::cmd_t cmd_q;
	logic [63:0] key_q, value_q, hash_q, rkey_q, rval_q;
	logic [1:0]  rflags_q;
	logic [BW-1:0] byte_q;
	logic [IW-1:0] idx_q, tomb_q, clr_q;
	logic [IW:0]   scan_q;
	logic          have_tomb_q;
	logic [10:0]   count_q;
	logic [7:0]    kbyte;
	logic [63:0]   hx;
	logic          hit, cur_tomb, ins_free, ins_tomb, wr_en;
	logic [IW-1:0] wr_idx;

	assign kbyte = key_q[{byte_q, 3'b000} +: 8];
	assign hx = hash_q ^ {56'd0, kbyte};

	assign sts.hash_last = (byte_q == BW'(KEY_BYTES - 1));
	assign sts.clr_last = (clr_q == IW'(SLOTS - 1));
	assign sts.slot_live = rflags_q[0];
	assign sts.slot_used = rflags_q[1];
	assign sts.key_match = (rkey_q == key_q);
	assign sts.scan_last = (scan_q == (IW + 1)'(SLOTS - 1));

	assign hit = rflags_q[0] && (rkey_q == key_q);
	assign cur_tomb = !rflags_q[0] && rflags_q[1];
	assign ins_free = !rflags_q[1];
	assign ins_tomb = have_tomb_q || cur_tomb;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= key & KMASK;
			value_q <= value;
			cmd_q <= cmd;
			hash_q <= lpht_pkg::FNV_BASIS;
			byte_q <= '0;
		end
		if (ctl.hash_step) begin
			hash_q <= (hx << lpht_pkg::HASH_MULT_SHIFT) + (hx * lpht_pkg::HASH_MULT_LOW);
			byte_q <= byte_q + BW'(1);
		end
		rkey_q <= slot_key[idx_q];
		rval_q <= slot_value[idx_q];
		if (wr_en) begin
			slot_key[wr_idx] <= key_q;
			slot_value[wr_idx] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		rflags_q <= slot_flags[idx_q];
		if (ctl.clr_step) slot_flags[clr_q] <= 2'b00;
		else if (ctl.finish && cmd_q != lpht_pkg::CMD_CLEAR) begin
			if (cmd_q == lpht_pkg::CMD_REMOVE && hit)
				slot_flags[idx_q] <= 2'b10;
			else if (wr_en)
				slot_flags[wr_idx] <= 2'b11;
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_idx = idx_q;
		if (ctl.finish && cmd_q == lpht_pkg::CMD_INSERT) begin
			if (hit) wr_en = 1'b1;
			else if (ins_tomb) begin
				wr_en = 1'b1;
				wr_idx = have_tomb_q ? tomb_q : idx_q;
			end else if (ins_free) wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			scan_q <= '0;
			tomb_q <= '0;
			have_tomb_q <= 1'b0;
			res_found <= 1'b0;
			res_status <= lpht_pkg::ST_DONE;
			res_value <= '0;
			res_count <= '0;
		end else begin
			if (ctl.clr_start) clr_q <= '0;
			else if (ctl.clr_step) clr_q <= clr_q + IW'(1);
			if (ctl.set_home) begin
				idx_q <= hash_q[IW-1:0];
				scan_q <= '0;
				have_tomb_q <= 1'b0;
			end
			if (ctl.probe_step) begin
				if (cur_tomb && !have_tomb_q) begin
					have_tomb_q <= 1'b1;
					tomb_q <= idx_q;
				end
				idx_q <= idx_q + IW'(1);
				scan_q <= scan_q + (IW + 1)'(1);
			end
			if (ctl.finish) begin
				res_value <= '0;
				res_found <= 1'b0;
				res_status <= lpht_pkg::ST_DONE;
				res_count <= count_q;
				unique case (cmd_q)
					lpht_pkg::CMD_CLEAR: begin
						count_q <= '0;
						res_count <= '0;
					end
					lpht_pkg::CMD_GET: begin
						res_found <= hit;
						res_status <= hit ? lpht_pkg::ST_DONE : lpht_pkg::ST_MISSING;
						if (hit) res_value <= rval_q;
					end
					lpht_pkg::CMD_REMOVE: begin
						res_found <= hit;
						res_status <= hit ? lpht_pkg::ST_DONE : lpht_pkg::ST_MISSING;
						if (hit) begin
							count_q <= count_q - 11'd1;
							res_count <= count_q - 11'd1;
						end
					end
					lpht_pkg::CMD_INSERT: begin
						res_found <= hit;
						if (!hit && (ins_tomb || ins_free)) begin
							count_q <= count_q + 11'd1;
							res_count <= count_q + 11'd1;
						end else if (!hit)
							res_status <= lpht_pkg::ST_FULL;
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table: controller, datapath, output register.
// Uses lpht_pkg, lpht_ctrl, lpht_dp.
//
// channel | dir | contents
// s_axis  | in  | tdata: key[63:0], value[127:64]; tuser: cmd[1:0]
// m_axis  | out | tdata: status[1:0], value_out[65:2], live_count[76:66] (80 bits); tuser: found
//
// A command hashes KEY_BYTES bytes (shift plus small constant multiply each),
// then reads and compares each probed slot; clear steps through all SLOTS flags.
// After reset a flag clearing pass over all SLOTS runs; s_axis_tready stays low.
// One command at a time; the next is taken once the result transfer has left.
`timescale 1ns / 1ps
module linear_probe_hash_table #(
	parameter int SLOTS = 1024,
	parameter int KEY_BYTES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // key, value
	input  logic [1:0]   s_axis_tuser,   // cmd
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [79:0]  m_axis_tdata,   // status, value_out, live_count, zero pad
	output logic         m_axis_tuser    // found
);
	lpht_pkg::ctl_t ctl;
	lpht_pkg::sts_t sts;
	lpht_pkg::cmd_t cmd;
	logic idle, in_fire;
	logic res_found;
	lpht_pkg::status_t res_status;
	logic [63:0] res_value;
	logic [10:0] res_count;

	assign cmd = lpht_pkg::cmd_t'(s_axis_tuser);
	assign s_axis_tready = idle;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	lpht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .cmd(cmd),
		.out_busy(m_axis_tvalid), .sts(sts), .ctl(ctl), .idle(idle)
	);

	lpht_dp #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .cmd(cmd),
		.key(s_axis_tdata[63:0]), .value(s_axis_tdata[127:64]), .sts(sts),
		.res_found(res_found), .res_status(res_status), .res_value(res_value),
		.res_count(res_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (ctl.finish) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	assign m_axis_tdata = {3'd0, res_count, res_value, res_status};
	assign m_axis_tuser = res_found;
endmodule

// ===== rtl/lpht_checker.sv =====
// Port checker for the linear probe hash table, bound to the top level.
// Depends on lpht_pkg and linear_probe_hash_table.
`timescale 1ns / 1ps
module lpht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second command taken while busy");
	a_no_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("command taken with result pending");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == lpht_pkg::ST_DONE)
		else $error("found with error status");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[65:2] == 64'd0)
		else $error("value on miss");
endmodule

bind linear_probe_hash_table lpht_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// ===== tb/linear_probe_hash_table_tb.sv =====
// Self-checking testbench for linear_probe_hash_table: directed and random commands.
// Depends on lpht_pkg and the linear_probe_hash_table RTL; a scoreboard class predicts results.
`timescale 1ns / 1ps
module linear_probe_hash_table_tb;
	localparam int TBL_SLOTS = 1024;

	typedef struct {
		logic              found;
		lpht_pkg::status_t status;
		logic [63:0]       value_out;
		logic [10:0]       live_count;
	} reply_t;

	class table_scoreboard;
		logic [63:0] keys [TBL_SLOTS];
		logic [63:0] vals [TBL_SLOTS];
		bit          live [TBL_SLOTS];
		bit          used [TBL_SLOTS];
		int unsigned count;
		reply_t      pending [$];
		int unsigned errors;
		int unsigned checked;
		int unsigned hits;
		int unsigned fulls;

		function new();
			count = 0;
			errors = 0;
			checked = 0;
			hits = 0;
			fulls = 0;
			foreach (live[i]) begin
				live[i] = 0;
				used[i] = 0;
				keys[i] = '0;
				vals[i] = '0;
			end
		endfunction

		function logic [63:0] key_hash(logic [63:0] k);
			logic [63:0] h;
			h = lpht_pkg::FNV_BASIS;
			for (int b = 0; b < 8; b++) begin
				h = h ^ {56'd0, k[8*b +: 8]};
				h = h * lpht_pkg::HASH_MULT;
			end
			return h;
		endfunction

		function void note(lpht_pkg::cmd_t cmd, logic [63:0] k, logic [63:0] v);
			reply_t r;
			int unsigned idx, tomb;
			bit have_tomb, done;
			logic [63:0] h;
			r.found = 0;
			r.status = lpht_pkg::ST_DONE;
			r.value_out = '0;
			have_tomb = 0;
			done = 0;
			tomb = 0;
			if (cmd == lpht_pkg::CMD_CLEAR) begin
				foreach (live[i]) begin
					live[i] = 0;
					used[i] = 0;
				end
				count = 0;
			end else begin
				h = key_hash(k);
				idx = 32'(h & 64'(TBL_SLOTS - 1));
				for (int n = 0; n < TBL_SLOTS && !done; n++) begin
					if (live[idx]) begin
						if (keys[idx] == k) begin
							r.found = 1;
							if (cmd == lpht_pkg::CMD_GET) r.value_out = vals[idx];
							else if (cmd == lpht_pkg::CMD_INSERT) vals[idx] = v;
							else begin
								live[idx] = 0;
								count--;
							end
							done = 1;
						end
					end else if (used[idx]) begin
						if (!have_tomb) begin
							have_tomb = 1;
							tomb = idx;
						end
					end else begin
						if (cmd == lpht_pkg::CMD_INSERT) begin
							if (!have_tomb) tomb = idx;
							keys[tomb] = k;
							vals[tomb] = v;
							live[tomb] = 1;
							used[tomb] = 1;
							count++;
						end
						done = 1;
					end
					if (!done) idx = (idx + 1) & (TBL_SLOTS - 1);
				end
				if (!r.found) begin
					if (cmd == lpht_pkg::CMD_INSERT) begin
						if (!done) begin
							if (have_tomb) begin
								keys[tomb] = k;
								vals[tomb] = v;
								live[tomb] = 1;
								count++;
							end else begin
								r.status = lpht_pkg::ST_FULL;
							end
						end
					end else begin
						r.status = lpht_pkg::ST_MISSING;
					end
				end
			end
			r.live_count = count[10:0];
			pending.push_back(r);
		endfunction

		function void check(logic fnd, logic [1:0] st, logic [63:0] vo, logic [10:0] lc);
			reply_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transfer: found %0d status %0d", fnd, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.found) hits++;
			if (e.status == lpht_pkg::ST_FULL) fulls++;
			if (fnd !== e.found) begin
				$error("found: expected %0d actual %0d", e.found, fnd);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d actual %0d", e.status, st);
				errors++;
			end
			if (vo !== e.value_out) begin
				$error("value_out: expected %h actual %h", e.value_out, vo);
				errors++;
			end
			if (lc !== e.live_count) begin
				$error("live_count: expected %0d actual %0d", e.live_count, lc);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [79:0]  m_axis_tdata;
	logic         m_axis_tuser;

	table_scoreboard sb;
	bit              no_idle;
	logic [63:0]     key_pool [32];

	linear_probe_hash_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

	always @(negedge clk)
		m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 37);

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[65:2],
				m_axis_tdata[76:66]);

	task automatic send(lpht_pkg::cmd_t cmd, logic [63:0] k, logic [63:0] v);
		while (!no_idle && $urandom_range(0, 99) < 37) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {v, k};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		sb.note(cmd, k, v);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		int unsigned pick;
		logic [63:0] k;
		lpht_pkg::cmd_t cmd;
		sb = new();
		no_idle = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = lpht_pkg::CMD_GET;
		foreach (key_pool[i]) key_pool[i] = rand64();
		repeat (5) @(negedge clk);
		arst_n = 1;

		send(lpht_pkg::CMD_GET, 64'd0, rand64());
		send(lpht_pkg::CMD_REMOVE, 64'd0, rand64());
		send(lpht_pkg::CMD_INSERT, 64'd0, 64'd0);
		send(lpht_pkg::CMD_INSERT, '1, '1);
		send(lpht_pkg::CMD_GET, 64'd0, '0);
		send(lpht_pkg::CMD_GET, '1, 64'd0);
		send(lpht_pkg::CMD_INSERT, '1, 64'h0123456789ABCDEF);
		send(lpht_pkg::CMD_GET, '1, '1);
		send(lpht_pkg::CMD_REMOVE, '1, '0);
		send(lpht_pkg::CMD_REMOVE, '1, '0);
		send(lpht_pkg::CMD_GET, '1, '0);
		send(lpht_pkg::CMD_INSERT, '1, 64'h5555AAAA5555AAAA);
		send(lpht_pkg::CMD_GET, '1, '0);
		send(lpht_pkg::CMD_CLEAR, rand64(), rand64());
		send(lpht_pkg::CMD_GET, 64'd0, '0);
		send(lpht_pkg::CMD_INSERT, 64'h8000000000000001, 64'hAAAA5555AAAA5555);
		send(lpht_pkg::CMD_GET, 64'h8000000000000001, '0);

		for (int n = 0; n < 383; n++) begin
			no_idle = (n >= 150 && n < 220);
			pick = $urandom_range(0, 99);
			if (pick < 35) cmd = lpht_pkg::CMD_GET;
			else if (pick < 72) cmd = lpht_pkg::CMD_INSERT;
			else if (pick < 97) cmd = lpht_pkg::CMD_REMOVE;
			else cmd = lpht_pkg::CMD_CLEAR;
			k = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, 31)];
			send(cmd, k, rand64());
		end
		s_axis_tvalid <= 1'b0;
		no_idle = 0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("covered %0d results: %0d key hits, %0d table-full replies",
			sb.checked, sb.hits, sb.fulls);
		$display("commands: get, insert, replace, remove, clear, tombstone reuse");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
